@@ hw/rtl/lef_pkg.sv @@
// shared types, constants and register codes of the laplacian edge filter
package lef_pkg;

   // one rgb888 pixel
   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pixel_type;

   localparam int MAX_WIDTH_DEFAULT = 1024;

   localparam int FRAME_WIDTH_BITS  = 11;
   localparam int FRAME_HEIGHT_BITS = 13;
   localparam int ROW_COUNT_BITS    = 13;
   localparam int CSR_INDEX_BITS    = 1;
   localparam int CSR_DATA_BITS     = 13;

   localparam logic [FRAME_WIDTH_BITS-1:0]  FRAME_WIDTH_RESET  = 11'd1024;
   localparam logic [FRAME_HEIGHT_BITS-1:0] FRAME_HEIGHT_RESET = 13'd1;
   localparam logic [ROW_COUNT_BITS-1:0]    ROW_COUNT_MAX      = 13'd8191;

   // configuration register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_WIDTH  = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_HEIGHT = 1'd1;

   // item kinds carried on tuser
   localparam logic CMD_PIXEL = 1'b0;
   localparam logic CMD_DRAIN = 1'b1;

   // saturation limit of one channel
   localparam logic [7:0] CHANNEL_MAX = 8'd255;

endpackage

@@ hw/rtl/laplacian_edge_filter_rgb.sv @@
// top level of the rgb laplacian edge filter
// Takes one pixel or drain transaction per clock while the result port is not stalled
// and gives at most one result per transaction, one row late: pixel (r, c) comes out
// when pixel (r+1, c) goes in, and after the last frame pixel frame_width drain
// transactions flush the final row. A transaction that yields a result loads the line
// store reads and the input stage at acceptance, then the result register when the
// first stage advances, and so reaches the result port; the rate of one transaction
// per clock without stall is set by the two-read-port row stores, with the previous
// pixel's pending store write forwarded to the next read. Row stores are not
// cleared after reset: no clearing pass, the block is ready at once.
module laplacian_edge_filter_rgb #(
   parameter int MAX_WIDTH = lef_pkg::MAX_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   // input pixels
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [23:0]                         req_tdata,  // in_red, in_green, in_blue
   input  logic                                req_tuser,  // cmd
   // results
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [23:0]                         rsp_tdata,  // out_red, out_green, out_blue
   output logic                                rsp_tlast,  // frame_last
   // configuration writes
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [lef_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [lef_pkg::CSR_DATA_BITS-1:0]   csr_data
);

   localparam int AW = $clog2(MAX_WIDTH);
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int CW = (WW > lef_pkg::FRAME_WIDTH_BITS) ? WW : lef_pkg::FRAME_WIDTH_BITS;
   localparam int RW = lef_pkg::ROW_COUNT_BITS;

   // first stage control
   typedef struct packed {
      logic [AW-1:0] col;
      logic          row0;
      logic          top;
      logic          left_ok;
      logic          last_col;
      logic          drain;
      logic          frame_last;
   } stage_type;

   // configuration registers
   logic [lef_pkg::FRAME_WIDTH_BITS-1:0]  frame_width_ff;
   logic [lef_pkg::FRAME_HEIGHT_BITS-1:0] frame_height_ff;

   // position state
   logic [AW-1:0] column_index_ff, column_index_in;
   logic [RW-1:0] row_index_ff, row_index_in;
   logic          drain_phase_ff, drain_phase_in;

   // stage registers
   logic               s1_valid_ff, s1_valid_in;
   stage_type          s1_ff, s1_in;
   lef_pkg::pixel_type s1_pix_ff;
   logic               out_valid_ff, out_valid_in;
   lef_pkg::pixel_type out_pix_ff;
   logic               out_last_ff;

   // forwarding of the pending store write
   logic               fwd_mid_sel_ff, fwd_rt_sel_ff, fwd_up_sel_ff, fwd_lf_sel_ff;
   lef_pkg::pixel_type fwd_pix_ff, fwd_mid_ff;

   logic               cmd_drain;
   lef_pkg::pixel_type in_pix;
   logic [CW-1:0]      fw_ext, w_wide;
   logic [WW-1:0]      eff_w, col_ext, c_wide;
   logic [AW-1:0]      c, c_plus, c_minus;
   logic               last_col, drop, accept, enter_s1, out_free, s1_adv;

   lef_pkg::pixel_type cen_q_a, cen_q_b, abv_q_a, abv_q_b;
   lef_pkg::pixel_type mid, up, dn, lf, rt, lap;

   // configuration port
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= lef_pkg::FRAME_WIDTH_RESET;
         frame_height_ff <= lef_pkg::FRAME_HEIGHT_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            lef_pkg::CSR_FRAME_WIDTH:
               frame_width_ff <= csr_data[lef_pkg::FRAME_WIDTH_BITS-1:0];
            lef_pkg::CSR_FRAME_HEIGHT:
               frame_height_ff <= csr_data[lef_pkg::FRAME_HEIGHT_BITS-1:0];
            default: ;
         endcase
      end
   end

   // effective width and current column
   assign fw_ext   = CW'(frame_width_ff);
   assign w_wide   = (fw_ext == '0) ? CW'(1) :
                     ((fw_ext > CW'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : fw_ext);
   assign eff_w    = w_wide[WW-1:0];
   assign col_ext  = WW'(column_index_ff);
   assign c_wide   = (col_ext >= eff_w) ? WW'(eff_w - 1'b1) : col_ext;
   assign c        = c_wide[AW-1:0];
   assign last_col = (c_wide == WW'(eff_w - 1'b1));
   assign c_plus   = AW'(c + 1'b1);
   assign c_minus  = AW'(c - 1'b1);

   // input transaction
   assign cmd_drain = (req_tuser == lef_pkg::CMD_DRAIN);
   assign in_pix    = '{red: req_tdata[7:0], green: req_tdata[15:8], blue: req_tdata[23:16]};
   assign drop      = (!cmd_drain && drain_phase_ff) || (cmd_drain && row_index_ff == '0);

   assign out_free   = !out_valid_ff || rsp_tready;
   assign s1_adv     = s1_valid_ff && out_free;
   assign req_tready = !s1_valid_ff || out_free;
   assign accept     = req_tvalid && req_tready;
   assign enter_s1   = accept && !drop;

   // position update
   always_comb begin
      column_index_in = column_index_ff;
      row_index_in    = row_index_ff;
      drain_phase_in  = drain_phase_ff;
      if (enter_s1) begin
         if (last_col) begin
            column_index_in = '0;
            if (cmd_drain) begin
               row_index_in   = '0;
               drain_phase_in = 1'b0;
            end else if (row_index_ff < lef_pkg::ROW_COUNT_MAX) begin
               row_index_in = RW'(row_index_ff + 1'b1);
            end
         end else begin
            column_index_in = c_plus;
            if (cmd_drain) begin
               drain_phase_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_index_ff <= '0;
         row_index_ff    <= '0;
         drain_phase_ff  <= 1'b0;
      end else begin
         column_index_ff <= column_index_in;
         row_index_ff    <= row_index_in;
         drain_phase_ff  <= drain_phase_in;
      end
   end

   // first stage
   always_comb begin
      s1_in.col        = c;
      s1_in.row0       = (row_index_ff == '0);
      s1_in.top        = (row_index_ff == RW'(1));
      s1_in.left_ok    = (c != '0);
      s1_in.last_col   = last_col;
      s1_in.drain      = cmd_drain;
      s1_in.frame_last = last_col && (frame_height_ff != '0) &&
                         (row_index_ff == RW'(frame_height_ff));
      if (enter_s1) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enter_s1) begin
         s1_ff     <= s1_in;
         s1_pix_ff <= in_pix;
      end
   end

   // forward the write that leaves the first stage at this edge
   always_ff @(posedge clock) begin
      if (enter_s1) begin
         fwd_mid_sel_ff <= s1_valid_ff && !s1_ff.drain && (s1_ff.col == c);
         fwd_rt_sel_ff  <= s1_valid_ff && !s1_ff.drain && (s1_ff.col == c_plus);
         fwd_up_sel_ff  <= s1_valid_ff && !s1_ff.row0 && (s1_ff.col == c);
         fwd_lf_sel_ff  <= s1_valid_ff && !s1_ff.row0 && (s1_ff.col == c_minus);
         fwd_pix_ff     <= s1_pix_ff;
         fwd_mid_ff     <= mid;
      end
   end

   // row stores: centre holds the last full row, above the row before it
   lef_line_store #(
      .DEPTH (MAX_WIDTH),
      .AW    (AW)
   ) u_centre_store (
      .clock     (clock),
      .rd_en     (enter_s1),
      .rd_addr_a (c),
      .rd_addr_b (c_plus),
      .rd_data_a (cen_q_a),
      .rd_data_b (cen_q_b),
      .wr_en     (s1_adv && !s1_ff.drain),
      .wr_addr   (s1_ff.col),
      .wr_data   (s1_pix_ff)
   );

   lef_line_store #(
      .DEPTH (MAX_WIDTH),
      .AW    (AW)
   ) u_above_store (
      .clock     (clock),
      .rd_en     (enter_s1),
      .rd_addr_a (c),
      .rd_addr_b (c_minus),
      .rd_data_a (abv_q_a),
      .rd_data_b (abv_q_b),
      .wr_en     (s1_adv && !s1_ff.row0),
      .wr_addr   (s1_ff.col),
      .wr_data   (mid)
   );

   // neighbourhood with edge replication
   assign mid = fwd_mid_sel_ff ? fwd_pix_ff : cen_q_a;
   assign rt  = s1_ff.last_col ? mid : (fwd_rt_sel_ff ? fwd_pix_ff : cen_q_b);
   assign up  = s1_ff.top ? mid : (fwd_up_sel_ff ? fwd_mid_ff : abv_q_a);
   assign lf  = s1_ff.left_ok ? (fwd_lf_sel_ff ? fwd_mid_ff : abv_q_b) : mid;
   assign dn  = s1_ff.drain ? mid : s1_pix_ff;

   lef_kernel u_kernel (
      .up     (up),
      .dn     (dn),
      .lf     (lf),
      .rt     (rt),
      .mid    (mid),
      .result (lap)
   );

   // result register
   always_comb begin
      if (s1_adv && !s1_ff.row0) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv && !s1_ff.row0) begin
         out_pix_ff  <= lap;
         out_last_ff <= s1_ff.frame_last;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_pix_ff.blue, out_pix_ff.green, out_pix_ff.red};
   assign rsp_tlast  = out_last_ff;

   // a drain only runs once a full row is held
   assert property (@(posedge clock) disable iff (reset)
      drain_phase_ff |-> (row_index_ff != '0))
      else $error("drain in progress with no stored row");

   // a stalled first stage keeps its transaction
   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !out_free) |=> s1_valid_ff)
      else $error("first stage lost a transaction under backpressure");

   // a kept transaction reaches the first stage
   assert property (@(posedge clock) disable iff (reset)
      enter_s1 |=> s1_valid_ff)
      else $error("accepted transaction missing from first stage");

   // a result only follows a first stage transaction
   assert property (@(posedge clock) disable iff (reset)
      (!out_valid_ff && !s1_valid_ff) |=> !out_valid_ff)
      else $error("result appeared without a transaction");

endmodule

@@ hw/rtl/lef_line_store.sv @@
// one row store: one write port and two registered read ports
module lef_line_store #(
   parameter int DEPTH = lef_pkg::MAX_WIDTH_DEFAULT,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                  clock,
   input  logic                  rd_en,
   input  logic [AW-1:0]         rd_addr_a,
   input  logic [AW-1:0]         rd_addr_b,
   output lef_pkg::pixel_type    rd_data_a,
   output lef_pkg::pixel_type    rd_data_b,
   input  logic                  wr_en,
   input  logic [AW-1:0]         wr_addr,
   input  lef_pkg::pixel_type    wr_data
);

   lef_pkg::pixel_type mem [DEPTH];
   lef_pkg::pixel_type rd_a_ff;
   lef_pkg::pixel_type rd_b_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read ports, old data on a same-edge write
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff <= mem[rd_addr_a];
         rd_b_ff <= mem[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

@@ hw/rtl/lef_kernel.sv @@
// four-neighbour laplacian with absolute value and saturation, per channel
module lef_kernel (
   input  lef_pkg::pixel_type up,
   input  lef_pkg::pixel_type dn,
   input  lef_pkg::pixel_type lf,
   input  lef_pkg::pixel_type rt,
   input  lef_pkg::pixel_type mid,
   output lef_pkg::pixel_type result
);

   function automatic logic [7:0] lap_channel(input logic [7:0] u, input logic [7:0] d,
                                              input logic [7:0] l, input logic [7:0] r,
                                              input logic [7:0] m);
      logic [9:0]         ring;
      logic signed [10:0] diff;
      logic [10:0]        mag;
      ring = 10'(u) + 10'(d) + 10'(l) + 10'(r);
      diff = $signed({1'b0, ring}) - $signed({1'b0, m, 2'b00});
      mag  = diff[10] ? 11'(-diff) : 11'(diff);
      return (mag > 11'(lef_pkg::CHANNEL_MAX)) ? lef_pkg::CHANNEL_MAX : mag[7:0];
   endfunction

   assign result.red   = lap_channel(up.red, dn.red, lf.red, rt.red, mid.red);
   assign result.green = lap_channel(up.green, dn.green, lf.green, rt.green, mid.green);
   assign result.blue  = lap_channel(up.blue, dn.blue, lf.blue, rt.blue, mid.blue);

endmodule
